@@ hw/rtl/mdio_pkg.sv @@
// shared constants and command codes of the index odometer
package mdio_pkg;

    localparam int MAX_DIMS  = 4;
    localparam int CMD_W     = 3;
    localparam int SEL_W     = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [CMD_W-1:0] CMD_INC   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEC   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BEGIN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_END   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

    // bit 0 of the register index picks lower or upper bound, bits above pick the dimension
    localparam logic CFG_KIND_LOWER = 1'b0;
    localparam logic CFG_KIND_UPPER = 1'b1;

endpackage

@@ hw/rtl/mdio_step.sv @@
// next-index logic: carry and borrow chain over all dimensions
module mdio_step
    import mdio_pkg::*;
#(
    parameter int NUM_DIMS    = 4,
    parameter int INDEX_WIDTH = 16
)
(
    input  logic [CMD_W-1:0]                        cmd,
    input  logic [SEL_W-1:0]                        dim_select,
    input  logic [INDEX_WIDTH-1:0]                  new_index,
    input  logic [NUM_DIMS-1:0][INDEX_WIDTH-1:0]    idx_cur,
    input  logic [NUM_DIMS-1:0][INDEX_WIDTH-1:0]    lower,
    input  logic [NUM_DIMS-1:0][INDEX_WIDTH-1:0]    upper,
    output logic [NUM_DIMS-1:0][INDEX_WIDTH-1:0]    idx_next,
    output logic                                    wrap
);

    localparam logic [INDEX_WIDTH:0]   ONE_EXT = (INDEX_WIDTH+1)'(1);
    localparam logic [INDEX_WIDTH-1:0] ONE     = INDEX_WIDTH'(1);

    logic [NUM_DIMS-1:0] inc_hit;
    logic [NUM_DIMS-1:0] dec_hit;

    // the increment compare runs one bit wider so the top value does not alias the bound
    always_comb
    begin
        logic [INDEX_WIDTH:0] inc_ext;
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            inc_ext    = {idx_cur[d][INDEX_WIDTH-1], idx_cur[d]} + ONE_EXT;
            inc_hit[d] = (inc_ext == {upper[d][INDEX_WIDTH-1], upper[d]});
            dec_hit[d] = (idx_cur[d] == lower[d]);
        end
    end

    always_comb
    begin
        logic chain;
        chain    = 1'b0;
        idx_next = idx_cur;
        wrap     = 1'b0;
        case (cmd)
            CMD_INC:
            begin
                chain = 1'b1;
                for (int d = 0; d < NUM_DIMS; d++)
                begin
                    if (chain)
                    begin
                        idx_next[d] = inc_hit[d] ? lower[d] : idx_cur[d] + ONE;
                    end
                    chain = chain & inc_hit[d];
                end
                wrap = chain;
            end
            CMD_DEC:
            begin
                chain = 1'b1;
                for (int d = 0; d < NUM_DIMS; d++)
                begin
                    if (chain)
                    begin
                        idx_next[d] = dec_hit[d] ? upper[d] - ONE : idx_cur[d] - ONE;
                    end
                    chain = chain & dec_hit[d];
                end
                wrap = chain;
            end
            CMD_WRITE:
            begin
                for (int d = 0; d < NUM_DIMS; d++)
                begin
                    if (dim_select == SEL_W'(d))
                    begin
                        idx_next[d] = new_index;
                    end
                end
            end
            CMD_BEGIN:
            begin
                idx_next = lower;
            end
            CMD_END:
            begin
                idx_next = upper;
            end
            default:
            begin
                idx_next = idx_cur;
            end
        endcase
        // carry or borrow out of the last dimension parks the counter at the end state
        if (wrap)
        begin
            idx_next = upper;
        end
    end

endmodule

@@ hw/rtl/mdio_out_queue.sv @@
// two-word result queue that decouples the input from a stalled output
module mdio_out_queue
    import mdio_pkg::*;
#(
    parameter int DATA_W = 65
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output logic [DATA_W-1:0] head_data
);

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_FULL  = 2'd2;

    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic [DATA_W-1:0] ent0_reg;
    logic [DATA_W-1:0] ent1_reg;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != CNT_EMPTY);
    assign head_data = ent0_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_EMPTY;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (push && count_reg == CNT_ONE)
            begin
                ent0_reg <= push_data;
            end
            else
            begin
                ent0_reg <= ent1_reg;
            end
        end
        else if (push && count_reg == CNT_EMPTY)
        begin
            ent0_reg <= push_data;
        end
        if (push && !pop && count_reg == CNT_ONE)
        begin
            ent1_reg <= push_data;
        end
    end

endmodule

@@ hw/rtl/multi_dim_index_odometer_top.sv @@
// top level of the bounded multi-dimension index odometer
// One command word is taken in every cycle while the two-word result queue has room; the index
// registers and the result queue are written at the accepting edge. The whole step, including the
// carry or borrow chain through NUM_DIMS dimensions, is one combinational pass in front of the
// index registers, so the sustained rate is one word per clock while the output is not stalled.
// in_stall rises only when two results wait on a stalled output. The user must write bounds via
// the cfg port only while idle (not enforced); dimension fields from NUM_DIMS up read zero.
module multi_dim_index_odometer_top
    import mdio_pkg::*;
#(
    parameter int NUM_DIMS    = 4,
    parameter int INDEX_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [INDEX_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [CMD_W-1:0]              cmd,
    input  logic [SEL_W-1:0]              dim_select,
    input  logic signed [INDEX_WIDTH-1:0] new_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [INDEX_WIDTH-1:0] index_0,
    output logic signed [INDEX_WIDTH-1:0] index_1,
    output logic signed [INDEX_WIDTH-1:0] index_2,
    output logic signed [INDEX_WIDTH-1:0] index_3,
    output logic                          wrapped
);

    localparam int RES_W = MAX_DIMS * INDEX_WIDTH + 1;

    logic [NUM_DIMS-1:0][INDEX_WIDTH-1:0] idx_reg;
    logic [NUM_DIMS-1:0][INDEX_WIDTH-1:0] idx_next;
    logic [NUM_DIMS-1:0][INDEX_WIDTH-1:0] lower_reg;
    logic [NUM_DIMS-1:0][INDEX_WIDTH-1:0] upper_reg;
    logic                                 step_wrap;
    logic                                 in_accept;
    logic                                 out_accept;
    logic                                 queue_full;
    logic [MAX_DIMS-1:0][INDEX_WIDTH-1:0] res_idx;
    logic [RES_W-1:0]                     head_word;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign in_stall   = queue_full;

    genvar g;
    generate
        for (g = 0; g < NUM_DIMS; g++)
        begin : g_bound
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    lower_reg[g] <= '0;
                    upper_reg[g] <= INDEX_WIDTH'(1);
                end
                else if (cfg_write && cfg_index[CFG_IDX_W-1:1] == SEL_W'(g))
                begin
                    if (cfg_index[0] == CFG_KIND_UPPER)
                    begin
                        upper_reg[g] <= cfg_data;
                    end
                    else
                    begin
                        lower_reg[g] <= cfg_data;
                    end
                end
            end
        end
        for (g = 0; g < MAX_DIMS; g++)
        begin : g_res
            if (g < NUM_DIMS)
            begin : g_used
                assign res_idx[g] = idx_next[g];
            end
            else
            begin : g_unused
                assign res_idx[g] = '0;
            end
        end
    endgenerate

    mdio_step #(
        .NUM_DIMS    (NUM_DIMS),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_step (
        .cmd        (cmd),
        .dim_select (dim_select),
        .new_index  (new_index),
        .idx_cur    (idx_reg),
        .lower      (lower_reg),
        .upper      (upper_reg),
        .idx_next   (idx_next),
        .wrap       (step_wrap)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (in_accept)
        begin
            idx_reg <= idx_next;
        end
    end

    mdio_out_queue #(
        .DATA_W (RES_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data ({step_wrap, res_idx}),
        .full      (queue_full),
        .pop       (out_accept),
        .not_empty (out_valid),
        .head_data (head_word)
    );

    assign index_0 = head_word[INDEX_WIDTH-1:0];
    assign index_1 = head_word[2*INDEX_WIDTH-1:INDEX_WIDTH];
    assign index_2 = head_word[3*INDEX_WIDTH-1:2*INDEX_WIDTH];
    assign index_3 = head_word[4*INDEX_WIDTH-1:3*INDEX_WIDTH];
    assign wrapped = head_word[RES_W-1];

`ifndef SYNTH
    // only counting commands can run off the last dimension
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && step_wrap) |-> (cmd == CMD_INC || cmd == CMD_DEC))
        else $error("wrap raised by a non-counting command");

    // a read-only word leaves the indices alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd == CMD_READ) |=> (idx_reg == $past(idx_reg)))
        else $error("read-only word changed the indices");

    // begin loads every lower bound
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd == CMD_BEGIN) |=> (idx_reg == $past(lower_reg)))
        else $error("begin did not load the lower bounds");

    // a write to dimension 0 lands in the index register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd == CMD_WRITE && dim_select == SEL_W'(0))
        |=> (idx_reg[0] == $past(new_index)))
        else $error("index write to dimension 0 lost");
`endif

endmodule

@@ bench/multi_dim_index_odometer_top_tb.sv @@
// self-checking bench for the four-dimension index odometer with a predicting scoreboard
`timescale 1ns / 100ps

module multi_dim_index_odometer_top_tb;
    import mdio_pkg::*;

    localparam int NDIM = 4;
    localparam int IW   = 16;

    // codes past read only, which the block treats as read only
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef logic signed [IW-1:0] idx_t;
    typedef logic signed [IW:0]   wide_t;
    typedef idx_t bound_set_t [NDIM];

    typedef struct packed {
        logic [NDIM-1:0][IW-1:0] idx;
        logic                    wrap;
    } odo_result_t;

    class odometer_scoreboard;
        idx_t        lo [NDIM];
        idx_t        hi [NDIM];
        idx_t        cur [NDIM];
        odo_result_t expected_q [$];
        int          errors;
        int          results_seen;
        int          wraps_seen;

        function new();
            for (int d = 0; d < NDIM; d++)
            begin
                lo[d]  = '0;
                hi[d]  = 16'sd1;
                cur[d] = '0;
            end
            errors       = 0;
            results_seen = 0;
            wraps_seen   = 0;
        endfunction

        // one bit wider so the bound compares never overflow
        function wide_t widen(idx_t v);
            return {v[IW-1], v};
        endfunction

        function void set_bound(logic [CFG_IDX_W-1:0] reg_sel, idx_t data);
            if (reg_sel[0] == CFG_KIND_UPPER)
                hi[reg_sel[CFG_IDX_W-1:1]] = data;
            else
                lo[reg_sel[CFG_IDX_W-1:1]] = data;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void report(string what);
            if (errors < 40)
                $display("mismatch at %0t: %s", $time, what);
            errors++;
        endfunction

        // advance the predicted indices by one accepted word and queue the result
        function void note_word(logic [CMD_W-1:0] c, logic [SEL_W-1:0] sel, idx_t v);
            odo_result_t e;
            wide_t       nxt;
            bit          chain;
            chain = 1'b0;
            case (c)
                CMD_INC:
                begin
                    chain = 1'b1;
                    for (int d = 0; d < NDIM && chain; d++)
                    begin
                        nxt     = widen(cur[d]) + wide_t'(1);
                        chain   = (nxt == widen(hi[d]));
                        cur[d]  = chain ? lo[d] : nxt[IW-1:0];
                    end
                end
                CMD_DEC:
                begin
                    chain = 1'b1;
                    for (int d = 0; d < NDIM && chain; d++)
                    begin
                        nxt     = widen(cur[d]) - wide_t'(1);
                        chain   = (nxt == widen(lo[d]) - wide_t'(1));
                        cur[d]  = chain ? idx_t'(hi[d] - 1'b1) : nxt[IW-1:0];
                    end
                end
                CMD_WRITE:
                    if (sel < NDIM)
                        cur[sel] = v;
                CMD_BEGIN:
                    cur = lo;
                CMD_END:
                    cur = hi;
                default:
                    ;
            endcase
            // carry or borrow out of the top dimension parks everything at the end state
            if (chain)
                cur = hi;
            for (int d = 0; d < NDIM; d++)
                e.idx[d] = cur[d];
            e.wrap = chain;
            expected_q.push_back(e);
        endfunction

        function void check_word(odo_result_t got);
            odo_result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
                return;
            end
            want = expected_q.pop_front();
            for (int d = 0; d < NDIM; d++)
                if (got.idx[d] !== want.idx[d])
                    report($sformatf("result %0d index_%0d: got %0d, expected %0d",
                        results_seen, d, $signed(got.idx[d]), $signed(want.idx[d])));
            if (got.wrap !== want.wrap)
                report($sformatf("result %0d wrapped: got %b, expected %b",
                    results_seen, got.wrap, want.wrap));
            if (want.wrap)
                wraps_seen++;
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [IW-1:0]          cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [CMD_W-1:0]       cmd;
    logic [SEL_W-1:0]       dim_select;
    idx_t                   new_index;
    logic                   out_valid;
    logic                   out_stall;
    idx_t                   index_0;
    idx_t                   index_1;
    idx_t                   index_2;
    idx_t                   index_3;
    logic                   wrapped;

    odometer_scoreboard sb;
    bit quiet;
    int burst_left;
    int words_sent;
    int cfg_writes;
    int settings_done;

    multi_dim_index_odometer_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .dim_select (dim_select),
        .new_index  (new_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .index_0    (index_0),
        .index_1    (index_1),
        .index_2    (index_2),
        .index_3    (index_3),
        .wrapped    (wrapped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: runs of stall and runs of free cycles of random length, no stall while quiet
    initial
    begin : receiver
        int stall_left;
        int free_left;
        out_stall  = 1'b0;
        stall_left = 0;
        free_left  = 0;
        forever
        begin
            @(negedge clk);
            if (quiet)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                out_stall <= 1'b1;
            end
            else
            begin
                free_left = $urandom_range(0, 20);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        odo_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.idx[0] = index_0;
            got.idx[1] = index_1;
            got.idx[2] = index_2;
            got.idx[3] = index_3;
            got.wrap   = wrapped;
            sb.check_word(got);
        end
    end

    task automatic idle(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic send_word(logic [CMD_W-1:0] c, logic [SEL_W-1:0] sel, idx_t v);
        if (burst_left == 0)
        begin
            if (!quiet)
                idle($urandom_range(1, 8));
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge clk);
        in_valid   <= 1'b1;
        cmd        <= c;
        dim_select <= sel;
        new_index  <= v;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(c, sel, v);
        words_sent++;
    endtask

    // sender holds off until every queued result is back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] r, idx_t v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        sb.set_bound(r, v);
        cfg_writes++;
    endtask

    task automatic program_bounds(bound_set_t lo_v, bound_set_t hi_v);
        for (int d = 0; d < NDIM; d++)
        begin
            write_reg({d[1:0], CFG_KIND_LOWER}, lo_v[d]);
            write_reg({d[1:0], CFG_KIND_UPPER}, hi_v[d]);
        end
        @(negedge clk);
        cfg_write <= 1'b0;
        settings_done++;
    endtask

    task automatic make_bounds(int kind, output bound_set_t lo_v, output bound_set_t hi_v);
        for (int d = 0; d < NDIM; d++)
        begin
            case (kind)
                0:
                begin
                    lo_v[d] = idx_t'($urandom_range(0, 5));
                    hi_v[d] = lo_v[d] + idx_t'($urandom_range(1, 3));
                end
                1:
                begin
                    lo_v[d] = idx_t'($urandom_range(0, 6)) - 16'sd3;
                    hi_v[d] = lo_v[d] + idx_t'($urandom_range(1, 4));
                end
                2:
                begin
                    lo_v[d] = idx_t'($urandom);
                    hi_v[d] = idx_t'($urandom);
                end
                3:
                begin
                    lo_v[d] = 16'sh8000;
                    hi_v[d] = 16'sh7fff;
                end
                4:
                begin
                    // swapped extremes on even dimensions, empty ranges on odd ones
                    if (d % 2 == 0)
                    begin
                        lo_v[d] = 16'sh7fff;
                        hi_v[d] = 16'sh8000;
                    end
                    else
                    begin
                        lo_v[d] = idx_t'($urandom);
                        hi_v[d] = lo_v[d];
                    end
                end
                default:
                begin
                    case (d)
                        0:
                        begin
                            lo_v[d] = 16'sh7ffd;
                            hi_v[d] = 16'sh7fff;
                        end
                        1:
                        begin
                            lo_v[d] = 16'sh8000;
                            hi_v[d] = 16'sh8002;
                        end
                        2:
                        begin
                            lo_v[d] = idx_t'($urandom);
                            hi_v[d] = lo_v[d] + 16'sd1;
                        end
                        default:
                        begin
                            lo_v[d] = 16'sd1;
                            hi_v[d] = 16'sd3;
                        end
                    endcase
                end
            endcase
        end
    endtask

    task automatic directed();
        bound_set_t lo_v;
        bound_set_t hi_v;
        // reset bounds: every dimension has a single value
        send_word(CMD_READ, 2'd0, 16'sd0);
        send_word(CMD_INC, 2'd3, 16'sh7fff);
        send_word(CMD_READ, 2'd1, 16'sh8000);
        send_word(CMD_BEGIN, 2'd2, 16'shffff);
        send_word(CMD_DEC, 2'd0, 16'sd0);
        send_word(CMD_END, 2'd0, 16'sd0);
        send_word(CMD_SPARE_6, 2'd3, 16'shffff);
        send_word(CMD_SPARE_7, 2'd0, 16'sd0);
        drain();
        make_bounds(3, lo_v, hi_v);
        program_bounds(lo_v, hi_v);
        // top of the index range without reaching the upper bound
        send_word(CMD_WRITE, 2'd0, 16'sh7fff);
        send_word(CMD_INC, 2'd0, 16'sd0);
        send_word(CMD_WRITE, 2'd0, 16'sh8000);
        send_word(CMD_DEC, 2'd0, 16'sd0);
        send_word(CMD_WRITE, 2'd1, 16'shffff);
        send_word(CMD_WRITE, 2'd2, 16'sh7fff);
        send_word(CMD_WRITE, 2'd3, 16'sh8000);
        send_word(CMD_INC, 2'd0, 16'sd0);
        send_word(CMD_BEGIN, 2'd0, 16'sd0);
        // borrow through all four dimensions from the lower corner
        send_word(CMD_DEC, 2'd0, 16'sd0);
        send_word(CMD_END, 2'd0, 16'sd0);
        send_word(CMD_INC, 2'd0, 16'sd0);
        send_word(CMD_READ, 2'd0, 16'sd0);
    endtask

    task automatic random_phase(int n_words, bit pause_midway);
        int               sent;
        int               run;
        bit               paused;
        logic [CMD_W-1:0] c;
        logic [SEL_W-1:0] sel;
        idx_t             v;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_words)
        begin
            if (pause_midway && !paused && sent >= n_words / 2)
            begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 70)
            begin
                // counting run in one direction so carries ripple up and wrap
                c   = ($urandom_range(0, 2) == 0) ? CMD_DEC : CMD_INC;
                run = $urandom_range(1, 40);
                repeat (run)
                begin
                    sel = SEL_W'($urandom);
                    v   = idx_t'($urandom);
                    send_word(c, sel, v);
                    sent++;
                end
            end
            else
            begin
                sel = SEL_W'($urandom);
                v   = idx_t'($urandom);
                case ($urandom_range(0, 9))
                    4:       c = CMD_BEGIN;
                    5:       c = CMD_END;
                    6:       c = CMD_READ;
                    7:       c = ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
                    default:
                    begin
                        c = CMD_WRITE;
                        case ($urandom_range(0, 3))
                            0:       v = sb.lo[sel];
                            1:       v = sb.hi[sel] - 1'b1;
                            2:       v = sb.hi[sel];
                            default: ;
                        endcase
                    end
                endcase
                send_word(c, sel, v);
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        bound_set_t lo_v;
        bound_set_t hi_v;
        in_valid      = 1'b0;
        cmd           = CMD_READ;
        dim_select    = '0;
        new_index     = '0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        quiet         = 1'b0;
        burst_left    = 0;
        words_sent    = 0;
        cfg_writes    = 0;
        settings_done = 0;
        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed();
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            make_bounds(ph % 6, lo_v, hi_v);
            program_bounds(lo_v, hi_v);
            quiet = (ph == 0 || ph == 7);
            random_phase(172, ph == 3);
        end
        quiet = 1'b0;
        drain();
        repeat (5) @(posedge clk);

        $display("ran %0d command words through %0d bound settings (%0d register writes)",
            words_sent, settings_done, cfg_writes);
        $display("checked %0d results, %0d of them wrapped, %0d mismatches",
            sb.results_seen, sb.wraps_seen, sb.errors);
        if (sb.errors == 0)
            $display("** multi_dim_index_odometer_top: PASSED **");
        else
            $display("** multi_dim_index_odometer_top: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("** multi_dim_index_odometer_top: FAILED **");
        $finish;
    end

endmodule
